// File: hdl/fdat_pkg.sv
// Shared constants, register indexes and control/status types for the frame difference core
package fdat_pkg;

    localparam int MAX_DIMENSION = 4096;

    localparam int PIX_W   = 8;
    localparam int DIM_W   = 13;
    localparam int COUNT_W = $clog2(MAX_DIMENSION);
    localparam int SUM_W   = 32;
    localparam int GAIN_W  = 8;
    localparam int NUM_W   = GAIN_W + SUM_W;
    localparam int DEN_W   = 2 * DIM_W;
    localparam int STEP_W  = $clog2(PIX_W);
    localparam int IDX_W   = 2;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(480);
    localparam logic [GAIN_W-1:0] LIGHT_GAIN_RST  = GAIN_W'(1);
    localparam logic [PIX_W-1:0] INIT_THRESH_RST  = PIX_W'(20);
    localparam logic [PIX_W-1:0] PIXEL_MAX        = '1;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH       = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT      = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_LIGHT_GAIN        = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_INITIAL_THRESHOLD = IDX_W'(3);

    typedef struct packed {
        logic              accept;
        logic              mul;
        logic              check;
        logic              div_step;
        logic [STEP_W-1:0] step;
    } fdat_cmd_t;

    typedef struct packed {
        logic frame_end;
        logic quot_sat;
        logic out_free;
    } fdat_stat_t;

endpackage

// File: hdl/fdat_datapath.sv
// Datapath: config registers, difference/sum/counters, frame-end multiply and bit-serial divide
module fdat_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [fdat_pkg::IDX_W-1:0]    cfg_index,
    input  logic [fdat_pkg::DIM_W-1:0]    cfg_data,
    input  logic [fdat_pkg::PIX_W-1:0]    current_pixel,
    input  logic [fdat_pkg::PIX_W-1:0]    previous_pixel,
    input  logic                          out_stall,
    input  fdat_pkg::fdat_cmd_t           cmd,
    output fdat_pkg::fdat_stat_t          stat,
    output logic                          out_valid,
    output logic                          moving,
    output logic                          frame_done,
    output logic [fdat_pkg::PIX_W-1:0]    threshold_now
);

    localparam logic [fdat_pkg::DIM_W:0] MAX_DIM_EXT =
        (fdat_pkg::DIM_W+1)'(fdat_pkg::MAX_DIMENSION);

    logic [fdat_pkg::DIM_W-1:0]   width_reg;
    logic [fdat_pkg::DIM_W-1:0]   height_reg;
    logic [fdat_pkg::GAIN_W-1:0]  gain_reg;
    logic [fdat_pkg::PIX_W-1:0]   threshold_reg;
    logic [fdat_pkg::SUM_W-1:0]   sum_reg;
    logic [fdat_pkg::COUNT_W-1:0] col_reg;
    logic [fdat_pkg::COUNT_W-1:0] row_reg;
    logic [fdat_pkg::NUM_W-1:0]   rem_reg;
    logic [fdat_pkg::DEN_W-1:0]   den_reg;
    logic [fdat_pkg::PIX_W-1:0]   quot_reg;
    logic                         out_valid_reg;
    logic                         moving_reg;
    logic                         frame_done_reg;
    logic [fdat_pkg::PIX_W-1:0]   threshold_now_reg;

    logic [fdat_pkg::DIM_W-1:0]   width_eff;
    logic [fdat_pkg::DIM_W-1:0]   height_eff;
    logic [fdat_pkg::PIX_W-1:0]   diff;
    logic [fdat_pkg::SUM_W:0]     sum_wide;
    logic [fdat_pkg::SUM_W-1:0]   sum_next;
    logic                         line_end;
    logic                         frame_end;
    logic [fdat_pkg::NUM_W-1:0]   trial_den;
    logic                         trial_ok;
    logic [fdat_pkg::PIX_W-1:0]   quot_next;
    logic                         finish;
    logic [fdat_pkg::PIX_W-1:0]   thresh_new;

    always_comb
    begin
        if (width_reg == '0)
            width_eff = fdat_pkg::DIM_W'(1);
        else if ({1'b0, width_reg} > MAX_DIM_EXT)
            width_eff = fdat_pkg::DIM_W'(fdat_pkg::MAX_DIMENSION);
        else
            width_eff = width_reg;

        if (height_reg == '0)
            height_eff = fdat_pkg::DIM_W'(1);
        else if ({1'b0, height_reg} > MAX_DIM_EXT)
            height_eff = fdat_pkg::DIM_W'(fdat_pkg::MAX_DIMENSION);
        else
            height_eff = height_reg;
    end

    assign diff = (current_pixel >= previous_pixel) ? current_pixel - previous_pixel
                                                    : previous_pixel - current_pixel;

    assign sum_wide = {1'b0, sum_reg} + (fdat_pkg::SUM_W+1)'(diff);
    assign sum_next = sum_wide[fdat_pkg::SUM_W] ? '1 : sum_wide[fdat_pkg::SUM_W-1:0];

    assign line_end  = fdat_pkg::DIM_W'(col_reg) >= width_eff - fdat_pkg::DIM_W'(1);
    assign frame_end = line_end && (fdat_pkg::DIM_W'(row_reg) >= height_eff - fdat_pkg::DIM_W'(1));

    // Restoring divide, one quotient bit per step; quotient known to fit PIX_W bits
    assign trial_den = fdat_pkg::NUM_W'(den_reg) << cmd.step;
    assign trial_ok  = rem_reg >= trial_den;
    assign quot_next = quot_reg | (fdat_pkg::PIX_W'(trial_ok) << cmd.step);

    assign stat.frame_end = frame_end;
    assign stat.quot_sat  = rem_reg >= (fdat_pkg::NUM_W'(den_reg) << fdat_pkg::PIX_W);
    assign stat.out_free  = !out_valid_reg || !out_stall;

    assign finish     = (cmd.check && stat.quot_sat) ||
                        (cmd.div_step && (cmd.step == '0));
    assign thresh_new = cmd.check ? fdat_pkg::PIXEL_MAX : quot_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= fdat_pkg::FRAME_WIDTH_RST;
            height_reg    <= fdat_pkg::FRAME_HEIGHT_RST;
            gain_reg      <= fdat_pkg::LIGHT_GAIN_RST;
            threshold_reg <= fdat_pkg::INIT_THRESH_RST;
            sum_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    fdat_pkg::REG_FRAME_WIDTH:       width_reg     <= cfg_data;
                    fdat_pkg::REG_FRAME_HEIGHT:      height_reg    <= cfg_data;
                    fdat_pkg::REG_LIGHT_GAIN:        gain_reg      <= cfg_data[fdat_pkg::GAIN_W-1:0];
                    fdat_pkg::REG_INITIAL_THRESHOLD: threshold_reg <= cfg_data[fdat_pkg::PIX_W-1:0];
                    default: ;
                endcase
            end

            if (cmd.accept)
            begin
                sum_reg <= sum_next;
                if (line_end)
                begin
                    col_reg <= '0;
                    if (frame_end)
                        row_reg <= '0;
                    else
                        row_reg <= row_reg + fdat_pkg::COUNT_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + fdat_pkg::COUNT_W'(1);
                end
                out_valid_reg <= !frame_end;
            end
            else if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.mul)
                sum_reg <= '0;

            if (finish)
                threshold_reg <= thresh_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            moving_reg        <= diff > threshold_reg;
            frame_done_reg    <= frame_end;
            threshold_now_reg <= threshold_reg;
        end
        if (finish)
            threshold_now_reg <= thresh_new;
        if (cmd.mul)
        begin
            rem_reg <= fdat_pkg::NUM_W'(gain_reg) * fdat_pkg::NUM_W'(sum_reg);
            den_reg <= fdat_pkg::DEN_W'(width_eff) * fdat_pkg::DEN_W'(height_eff);
        end
        if (cmd.check)
            quot_reg <= '0;
        if (cmd.div_step)
        begin
            quot_reg <= quot_next;
            if (trial_ok)
                rem_reg <= rem_reg - trial_den;
        end
    end

    assign out_valid     = out_valid_reg;
    assign moving        = moving_reg;
    assign frame_done    = frame_done_reg;
    assign threshold_now = threshold_now_reg;

endmodule

// File: hdl/fdat_ctrl.sv
// Controller: pixel acceptance and frame-end threshold sequence
module fdat_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  fdat_pkg::fdat_stat_t stat,
    output logic                 in_stall,
    output fdat_pkg::fdat_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_RUN,
        S_MUL,
        S_CHECK,
        S_DIV
    } state_t;

    state_t                      state_reg;
    logic [fdat_pkg::STEP_W-1:0] step_reg;
    logic                        accept;

    assign in_stall = !((state_reg == S_RUN) && stat.out_free);
    assign accept   = in_valid && !in_stall;

    assign cmd.accept   = accept;
    assign cmd.mul      = state_reg == S_MUL;
    assign cmd.check    = state_reg == S_CHECK;
    assign cmd.div_step = state_reg == S_DIV;
    assign cmd.step     = step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_RUN:
                begin
                    if (accept && stat.frame_end)
                        state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (stat.quot_sat)
                        state_reg <= S_RUN;
                    else
                    begin
                        state_reg <= S_DIV;
                        step_reg  <= fdat_pkg::STEP_W'(fdat_pkg::PIX_W - 1);
                    end
                end
                S_DIV:
                begin
                    if (step_reg == '0)
                        state_reg <= S_RUN;
                    else
                        step_reg <= step_reg - fdat_pkg::STEP_W'(1);
                end
                default:
                begin
                    state_reg <= S_RUN;
                end
            endcase
        end
    end

endmodule

// File: hdl/frame_difference_adaptive_threshold_core.sv
// Top level of the frame difference motion mask core with adaptive threshold
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  input    | in_valid / in_stall   | current_pixel, previous_pixel
//  output   | out_valid / out_stall | moving, frame_done, threshold_now
//  config   | cfg_write             | cfg_index, cfg_data
//
// A request is taken every cycle while the output register is free or being emptied.
// The last pixel of a frame adds a multiply step, a saturation check and, unless the
// quotient saturates, eight divide steps of the restoring divider, with the input
// stalled meanwhile. Output stall holds the result register and stalls the input.
// Reset is asynchronous and loads the register defaults.
module frame_difference_adaptive_threshold_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [fdat_pkg::IDX_W-1:0]    cfg_index,
    input  logic [fdat_pkg::DIM_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fdat_pkg::PIX_W-1:0]    current_pixel,
    input  logic [fdat_pkg::PIX_W-1:0]    previous_pixel,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          moving,
    output logic                          frame_done,
    output logic [fdat_pkg::PIX_W-1:0]    threshold_now
);

    fdat_pkg::fdat_cmd_t  cmd;
    fdat_pkg::fdat_stat_t stat;

    fdat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    fdat_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .current_pixel  (current_pixel),
        .previous_pixel (previous_pixel),
        .out_stall      (out_stall),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .moving         (moving),
        .frame_done     (frame_done),
        .threshold_now  (threshold_now)
    );

    // no request taken while a result sits blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !(out_valid && out_stall))
        else $error("input request taken while output blocked");

    // frame-end request: result not shown until the threshold is done
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && stat.frame_end) |=> !out_valid)
        else $error("frame-end result shown before threshold update");

    // input stays stalled while the divider runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mul || cmd.check || cmd.div_step) |-> in_stall)
        else $error("input open during threshold update");

    // a new result that marks frame end follows a check or divide step of the threshold sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid) && frame_done) |-> $past(cmd.check || cmd.div_step))
        else $error("frame-end result without threshold sequence");

endmodule
